// ===== design/wsd_pkg.sv =====
package wsd_pkg;

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXT,
		PH_MASK,
		PH_PAYLOAD,
		PH_STOPPED
	} phase_t;

	typedef enum logic [2:0] {
		KIND_DATA      = 3'd0,
		KIND_DELIVERED = 3'd1,
		KIND_DROPPED   = 3'd2,
		KIND_CLOSE     = 3'd3,
		KIND_BAD_MASK  = 3'd4,
		KIND_TOO_LONG  = 3'd5
	} kind_t;

	localparam logic [31:0] MAX_FRAME_RESET = 32'd16777216;

	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] MASK_BYTES  = 4'd4;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [3:0]  opcode;
		logic [31:0] length;
		logic        rsv;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

// ===== design/wsd_if.sv =====
interface wsd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

interface wsd_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  out_kind;
	logic [7:0]  data_byte;
	logic [3:0]  msg_opcode;
	logic [31:0] message_length;
	logic        rsv_seen;
	logic        last;

	modport source(
		output valid, output out_kind, output data_byte, output msg_opcode,
		output message_length, output rsv_seen, output last, input ready
	);
	modport sink(
		input valid, input out_kind, input data_byte, input msg_opcode,
		input message_length, input rsv_seen, input last, output ready
	);
endinterface

interface wsd_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== design/websocket_frame_deframer.sv =====
// path: an accepted byte is registered, parsed combinationally, and its result words are
// written into the result queue, whose head drives res
// throughput: while input ready is high, one byte per cycle; a final frame's last payload
// byte yields two result words; the queue absorbs them while res takes one word per cycle
// input ready drops when the result queue holds more than QUEUE_DEPTH-4 words
// reset: asynchronous, active low; parser waits for a header byte, limit is 16777216
module websocket_frame_deframer import wsd_pkg::*; #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	wsd_rx_if.sink    rx,
	wsd_res_if.source res,
	wsd_cfg_if.sink   cfg
);

	logic [31:0] max_q;
	push_t       push;
	logic        space_ok;
	logic        head_valid;
	result_t     head;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_FRAME_RESET;
		end else if (cfg.valid) begin
			max_q <= cfg.data;
		end
	end

	assign rx.ready = space_ok;

	wsd_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (rx.valid && space_ok),
		.in_byte       (rx.rx_byte),
		.max_frame_len (max_q),
		.push          (push)
	);

	wsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (res.ready),
		.space_ok   (space_ok),
		.head_valid (head_valid),
		.head       (head)
	);

	assign res.valid          = head_valid;
	assign res.out_kind       = head.kind;
	assign res.data_byte      = head.data;
	assign res.msg_opcode     = head.opcode;
	assign res.message_length = head.length;
	assign res.rsv_seen       = head.rsv;
	assign res.last           = head.last;

endmodule

// ===== design/wsd_parser.sv =====
module wsd_parser import wsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [7:0]  in_byte,
	input  logic [31:0] max_frame_len,
	output push_t       push
);

	logic        valid_s1;
	logic [7:0]  byte_s1;

	phase_t      phase_q, phase_d;
	logic [7:0]  fhb_q, fhb_d;
	logic [3:0]  ebl_q, ebl_d;
	logic [63:0] flen_q, flen_d;
	logic [31:0] mkey_q, mkey_d;
	logic [31:0] pleft_q, pleft_d;
	logic [1:0]  midx_q, midx_d;
	logic [31:0] acc_q, acc_d;
	logic [3:0]  lop_q, lop_d;

	logic        rsv;
	logic        do_end;
	logic [3:0]  end_op;
	logic [31:0] end_len;
	logic [31:0] acc_inc;
	logic [7:0]  key_byte;
	logic        too_long;
	logic [3:0]  op_new;
	kind_t       end_kind;
	logic [1:0]  n;
	result_t     r0, r1, rend;

	function automatic result_t make_result(kind_t k, logic [7:0] d, logic [3:0] op,
		logic [31:0] len, logic rs);
		result_t r;
		r.kind   = k;
		r.data   = d;
		r.opcode = op;
		r.length = len;
		r.rsv    = rs;
		r.last   = 1'b0;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			fhb_q   <= '0;
			ebl_q   <= '0;
			flen_q  <= '0;
			mkey_q  <= '0;
			pleft_q <= '0;
			midx_q  <= '0;
			acc_q   <= '0;
			lop_q   <= '0;
		end else if (valid_s1) begin
			phase_q <= phase_d;
			fhb_q   <= fhb_d;
			ebl_q   <= ebl_d;
			flen_q  <= flen_d;
			mkey_q  <= mkey_d;
			pleft_q <= pleft_d;
			midx_q  <= midx_d;
			acc_q   <= acc_d;
			lop_q   <= lop_d;
		end
	end

	assign rsv      = |fhb_q[6:4];
	assign acc_inc  = (&acc_q) ? acc_q : acc_q + 32'd1;
	assign too_long = (|flen_q[63:32]) ||
		((max_frame_len != 32'd0) && (flen_q[31:0] > max_frame_len));
	assign op_new   = (acc_q == 32'd0) ? fhb_q[3:0] : lop_q;

	always_comb begin
		case (midx_q)
			2'd0:    key_byte = mkey_q[31:24];
			2'd1:    key_byte = mkey_q[23:16];
			2'd2:    key_byte = mkey_q[15:8];
			default: key_byte = mkey_q[7:0];
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		fhb_d   = fhb_q;
		ebl_d   = ebl_q;
		flen_d  = flen_q;
		mkey_d  = mkey_q;
		pleft_d = pleft_q;
		midx_d  = midx_q;
		acc_d   = acc_q;
		lop_d   = lop_q;
		n       = 2'd0;
		r0      = '0;
		r1      = '0;
		rend    = '0;
		do_end  = 1'b0;
		end_op  = lop_q;
		end_len = acc_q;
		end_kind = KIND_DROPPED;

		case (phase_q)
			PH_HDR0: begin
				fhb_d   = byte_s1;
				phase_d = PH_HDR1;
			end
			PH_HDR1: begin
				if (!byte_s1[7]) begin
					phase_d = PH_STOPPED;
					r0 = make_result(KIND_BAD_MASK, 8'd0, lop_q, acc_q, rsv);
					n  = 2'd1;
				end else begin
					mkey_d = '0;
					if (byte_s1[6:0] == LEN_EXT16) begin
						flen_d  = '0;
						ebl_d   = EXT16_BYTES;
						phase_d = PH_EXT;
					end else if (byte_s1[6:0] == LEN_EXT64) begin
						flen_d  = '0;
						ebl_d   = EXT64_BYTES;
						phase_d = PH_EXT;
					end else begin
						flen_d  = {57'd0, byte_s1[6:0]};
						ebl_d   = MASK_BYTES;
						phase_d = PH_MASK;
					end
				end
			end
			PH_EXT: begin
				flen_d = {flen_q[55:0], byte_s1};
				ebl_d  = ebl_q - 4'd1;
				if (ebl_q == 4'd1) begin
					ebl_d   = MASK_BYTES;
					phase_d = PH_MASK;
				end
			end
			PH_MASK: begin
				mkey_d = {mkey_q[23:0], byte_s1};
				ebl_d  = ebl_q - 4'd1;
				if (ebl_q == 4'd1) begin
					if (too_long) begin
						phase_d = PH_STOPPED;
						r0 = make_result(KIND_TOO_LONG, 8'd0, lop_q, acc_q, rsv);
						n  = 2'd1;
					end else begin
						lop_d   = op_new;
						pleft_d = flen_q[31:0];
						midx_d  = 2'd0;
						if (flen_q[31:0] == 32'd0) begin
							do_end  = 1'b1;
							end_op  = op_new;
							end_len = acc_q;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
				end
			end
			PH_PAYLOAD: begin
				midx_d  = midx_q + 2'd1;
				acc_d   = acc_inc;
				pleft_d = pleft_q - 32'd1;
				r0 = make_result(KIND_DATA, byte_s1 ^ key_byte, lop_q, acc_inc, rsv);
				n  = 2'd1;
				if (pleft_q == 32'd1) begin
					do_end  = 1'b1;
					end_op  = lop_q;
					end_len = acc_inc;
				end
			end
			default: begin
				phase_d = PH_STOPPED;
			end
		endcase

		if (do_end) begin
			if (!fhb_q[7]) begin
				phase_d = PH_HDR0;
			end else begin
				if (end_op == OP_TEXT || end_op == OP_BINARY) begin
					end_kind = KIND_DELIVERED;
				end else if (end_op == OP_CLOSE) begin
					end_kind = KIND_CLOSE;
				end else begin
					end_kind = KIND_DROPPED;
				end
				rend    = make_result(end_kind, 8'd0, end_op, end_len, rsv);
				phase_d = (end_kind == KIND_CLOSE) ? PH_STOPPED : PH_HDR0;
				acc_d   = '0;
				lop_d   = '0;
				if (n == 2'd0) begin
					r0 = rend;
				end else begin
					r1 = rend;
				end
				n = n + 2'd1;
			end
		end

		if (n == 2'd1) begin
			r0.last = 1'b1;
		end else if (n == 2'd2) begin
			r1.last = 1'b1;
		end

		push.count = valid_s1 ? n : 2'd0;
		push.r0    = r0;
		push.r1    = r1;
	end

endmodule

// ===== design/wsd_queue.sv =====
module wsd_queue import wsd_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	input  logic    pop,
	output logic    space_ok,
	output logic    head_valid,
	output result_t head
);

	localparam int AW = $clog2(DEPTH);

	result_t       mem [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          pop_ok;

	assign head_valid = (cnt_q != '0);
	assign pop_ok     = pop && head_valid;
	assign space_ok   = (cnt_q <= (AW+1)'(DEPTH - 4));
	assign head       = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + AW'(push.count);
			rd_q  <= rd_q + AW'(pop_ok);
			cnt_q <= cnt_q + (AW+1)'(push.count) - (AW+1)'(pop_ok);
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_entry
		always_ff @(posedge clk) begin
			if (push.count != 2'd0 && AW'(i) == wr_q) begin
				mem[i] <= push.r0;
			end else if (push.count == 2'd2 && AW'(i) == wr_q + AW'(1)) begin
				mem[i] <= push.r1;
			end
		end
	end

endmodule
